// ===== rtl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared constants, types and the CRC-16 step for the Modbus RTU register slave.
// ----------------------------------------------------------------------------
package mrs_pkg;

   localparam int REG_COUNT      = 8;
   localparam int REG_IDX_W      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int MAX_READ_WORDS = 8;
   localparam int HEAD_LEN       = 6;
   localparam int HEAD_IDX_W     = 3;
   localparam int MIN_FRAME      = 8;
   // reply body is at most address, function, count and MAX_READ_WORDS words
   localparam int IDX_W          = 5;
   localparam int FIFO_DEPTH     = 2;
   localparam int FIFO_PTR_W     = 1;
   localparam int FIFO_CNT_W     = 2;

   localparam logic [7:0]  FUNC_READ    = 8'h03;
   localparam logic [7:0]  FUNC_WRITE   = 8'h06;
   localparam logic [7:0]  ADDR_RESET   = 8'h01;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic        OP_BYTE      = 1'b0;
   localparam logic        OP_EOF       = 1'b1;

   typedef struct packed {
      logic                 is_write;
      logic [7:0]           slave;
      logic [REG_IDX_W-1:0] addr;
      logic [15:0]          val;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_BODY,
      BK_CRC_LO,
      BK_CRC_HI
   } back_state_type;

   // one byte folded into a Modbus CRC-16, LSB first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/mrs_if.sv =====
// ----------------------------------------------------------------------------
// mrs_if
// Valid/ready channel interfaces for received items and reply bytes.
// ----------------------------------------------------------------------------
interface mrs_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface mrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;

   modport source (output valid, output tx_byte, output last_byte, input ready);
   modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

// ===== rtl/mrs_front.sv =====
// ----------------------------------------------------------------------------
// mrs_front
// Frame capture: head bytes, byte count and running CRC; judges the frame at
// end of frame and queues a read or write command.
// ----------------------------------------------------------------------------
module mrs_front (
   input  logic                     clock,
   input  logic                     reset,
   mrs_req_if.sink                  req,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  mrs_pkg::fifo_status_type fifo_st,
   output logic                     push,
   output mrs_pkg::cmd_type         cmd
);

   logic [7:0]  head_ff [mrs_pkg::HEAD_LEN];
   logic [7:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  slave_ff, slave_in;

   logic        take;
   logic        frame_ok;
   logic [15:0] addr16, val16;
   logic        read_ok, write_ok;
   logic [16:0] span;

   assign req.ready = !fifo_st.full;
   assign take      = req.valid && req.ready;

   assign addr16 = {head_ff[2], head_ff[3]};
   assign val16  = {head_ff[4], head_ff[5]};
   assign span   = {1'b0, addr16} + {1'b0, val16};

   assign frame_ok = (cnt_ff >= 8'(mrs_pkg::MIN_FRAME)) && (crc_ff == 16'h0000)
                     && (head_ff[0] == slave_ff);
   assign read_ok  = (head_ff[1] == mrs_pkg::FUNC_READ) && (val16 != 16'h0000)
                     && (val16 <= 16'(mrs_pkg::MAX_READ_WORDS))
                     && (addr16 < 16'(mrs_pkg::REG_COUNT))
                     && (span <= 17'(mrs_pkg::REG_COUNT));
   assign write_ok = (head_ff[1] == mrs_pkg::FUNC_WRITE)
                     && (addr16 < 16'(mrs_pkg::REG_COUNT));

   assign push = take && (req.op == mrs_pkg::OP_EOF) && frame_ok && (read_ok || write_ok);

   always_comb begin
      cmd.is_write = write_ok;
      cmd.slave    = slave_ff;
      cmd.addr     = addr16[mrs_pkg::REG_IDX_W-1:0];
      cmd.val      = val16;
   end

   always_comb begin
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      slave_in = csr_wr_en ? csr_wr_data : slave_ff;
      if (take) begin
         if (req.op == mrs_pkg::OP_BYTE) begin
            crc_in = mrs_pkg::crc_fold(crc_ff, req.rx_byte);
            if (cnt_ff != 8'hFF) begin
               cnt_in = cnt_ff + 8'd1;
            end
         end else begin
            crc_in = mrs_pkg::CRC_INIT;
            cnt_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 8'd0;
         crc_ff   <= mrs_pkg::CRC_INIT;
         slave_ff <= mrs_pkg::ADDR_RESET;
      end else begin
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         slave_ff <= slave_in;
      end
   end

   // head bytes: payload only, no reset
   always_ff @(posedge clock) begin
      if (take && (req.op == mrs_pkg::OP_BYTE) && (cnt_ff < 8'(mrs_pkg::HEAD_LEN))) begin
         head_ff[cnt_ff[mrs_pkg::HEAD_IDX_W-1:0]] <= req.rx_byte;
      end
   end

endmodule

// ===== rtl/mrs_fifo.sv =====
// ----------------------------------------------------------------------------
// mrs_fifo
// Two-entry command queue between frame capture and reply generation.
// ----------------------------------------------------------------------------
module mrs_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mrs_pkg::cmd_type         push_cmd,
   input  logic                     pop,
   output mrs_pkg::cmd_type         pop_cmd,
   output mrs_pkg::fifo_status_type status
);

   mrs_pkg::cmd_type                entry_ff [mrs_pkg::FIFO_DEPTH];
   logic [mrs_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mrs_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mrs_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == mrs_pkg::FIFO_CNT_W'(mrs_pkg::FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/mrs_back.sv =====
// ----------------------------------------------------------------------------
// mrs_back
// Reply generator: holds the register file, carries out queued commands and
// streams the reply bytes with their CRC through an output register.
// ----------------------------------------------------------------------------
module mrs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mrs_pkg::fifo_status_type fifo_st,
   input  mrs_pkg::cmd_type         head_cmd,
   output logic                     pop,
   mrs_rsp_if.source                rsp
);

   mrs_pkg::back_state_type state_ff, state_in;

   logic [15:0]               regs_ff [mrs_pkg::REG_COUNT];
   mrs_pkg::cmd_type          cmd_ff, cmd_in;
   logic [mrs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]               crc_ff, crc_in;
   logic                      valid_ff, valid_in;
   logic [7:0]                tx_ff, tx_in;
   logic                      last_ff, last_in;

   logic                       out_free;
   logic                       emit;
   logic [7:0]                 body_byte;
   logic [mrs_pkg::IDX_W-1:0]  body_last;
   logic [mrs_pkg::IDX_W-1:0]  word_off;
   logic [mrs_pkg::REG_IDX_W-1:0] rd_addr;
   logic [15:0]                rd_word;
   logic [15:0]                addr_ext;

   assign out_free  = !valid_ff || rsp.ready;
   assign rsp.valid     = valid_ff;
   assign rsp.tx_byte   = tx_ff;
   assign rsp.last_byte = last_ff;

   // read reply body: address, function, byte count, then words high byte first
   assign word_off  = idx_ff - mrs_pkg::IDX_W'(3);
   assign rd_addr   = cmd_ff.addr + mrs_pkg::REG_IDX_W'(word_off[mrs_pkg::IDX_W-1:1]);
   assign rd_word   = regs_ff[rd_addr];
   assign addr_ext  = 16'(cmd_ff.addr);
   assign body_last = cmd_ff.is_write ? mrs_pkg::IDX_W'(5)
                                      : mrs_pkg::IDX_W'(2) + {cmd_ff.val[3:0], 1'b0};

   always_comb begin
      if (idx_ff == mrs_pkg::IDX_W'(0)) begin
         body_byte = cmd_ff.slave;
      end else if (idx_ff == mrs_pkg::IDX_W'(1)) begin
         body_byte = cmd_ff.is_write ? mrs_pkg::FUNC_WRITE : mrs_pkg::FUNC_READ;
      end else if (cmd_ff.is_write) begin
         unique case (idx_ff)
            mrs_pkg::IDX_W'(2): body_byte = addr_ext[15:8];
            mrs_pkg::IDX_W'(3): body_byte = addr_ext[7:0];
            mrs_pkg::IDX_W'(4): body_byte = cmd_ff.val[15:8];
            default:            body_byte = cmd_ff.val[7:0];
         endcase
      end else if (idx_ff == mrs_pkg::IDX_W'(2)) begin
         body_byte = {cmd_ff.val[6:0], 1'b0};
      end else begin
         body_byte = word_off[0] ? rd_word[7:0] : rd_word[15:8];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrs_pkg::BK_IDLE: begin
            if (!fifo_st.empty) state_in = mrs_pkg::BK_BODY;
         end
         mrs_pkg::BK_BODY: begin
            if (out_free && (idx_ff == body_last)) state_in = mrs_pkg::BK_CRC_LO;
         end
         mrs_pkg::BK_CRC_LO: begin
            if (out_free) state_in = mrs_pkg::BK_CRC_HI;
         end
         mrs_pkg::BK_CRC_HI: begin
            if (out_free) state_in = mrs_pkg::BK_IDLE;
         end
         default: state_in = mrs_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop      = 1'b0;
      emit     = 1'b0;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      tx_in    = tx_ff;
      last_in  = last_ff;
      unique case (state_ff)
         mrs_pkg::BK_IDLE: begin
            pop = !fifo_st.empty;
            if (pop) begin
               cmd_in = head_cmd;
               idx_in = '0;
               crc_in = mrs_pkg::CRC_INIT;
            end
         end
         mrs_pkg::BK_BODY: begin
            emit = out_free;
            if (emit) begin
               tx_in   = body_byte;
               last_in = 1'b0;
               crc_in  = mrs_pkg::crc_fold(crc_ff, body_byte);
               idx_in  = idx_ff + 1'b1;
            end
         end
         mrs_pkg::BK_CRC_LO: begin
            emit = out_free;
            if (emit) begin
               tx_in   = crc_ff[7:0];
               last_in = 1'b0;
            end
         end
         mrs_pkg::BK_CRC_HI: begin
            emit = out_free;
            if (emit) begin
               tx_in   = crc_ff[15:8];
               last_in = 1'b1;
            end
         end
         default: ;
      endcase
      valid_in = emit || (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrs_pkg::BK_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < mrs_pkg::REG_COUNT; i++) begin
            regs_ff[i] <= 16'(i + 1);
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         // write commands update the file before their echo goes out
         if (pop && head_cmd.is_write) begin
            regs_ff[head_cmd.addr] <= head_cmd.val;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      crc_ff  <= crc_in;
      tx_ff   <= tx_in;
      last_ff <= last_in;
   end

endmodule

// ===== rtl/modbus_rtu_register_slave_top.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_top
// Modbus RTU slave for a small holding-register file (functions 3 and 6).
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  req_ch    in   valid/ready     op, rx_byte
//  rsp_ch    out  valid/ready     tx_byte, last_byte
//  csr_*     in   csr_wr_en       csr_wr_data (own slave address)
//
//  Capture takes one received byte or end-of-frame marker per cycle unless the
//  queue is full; frames are judged in the cycle the marker is taken. The
//  register file stage streams replies at one byte per cycle while rsp_ch is
//  ready, once the command is fetched; a read of n words gives 5 + 2n bytes, a
//  write 8. A two-entry command queue sits between the stages; req_ch stalls
//  only when it is full. Reset is synchronous; register i resets to i + 1.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave_top (
   input  logic       clock,
   input  logic       reset,
   mrs_req_if.sink    req_ch,
   mrs_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic                     fifo_push;
   logic                     fifo_pop;
   mrs_pkg::cmd_type         push_cmd;
   mrs_pkg::cmd_type         pop_cmd;
   mrs_pkg::fifo_status_type fifo_st;

   mrs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fifo_st     (fifo_st),
      .push        (fifo_push),
      .cmd         (push_cmd)
   );

   mrs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_cmd (push_cmd),
      .pop      (fifo_pop),
      .pop_cmd  (pop_cmd),
      .status   (fifo_st)
   );

   mrs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .fifo_st  (fifo_st),
      .head_cmd (pop_cmd),
      .pop      (fifo_pop),
      .rsp      (rsp_ch)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_st.full)
      else $error("command pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_st.empty)
      else $error("command popped from an empty queue");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("reply valid straight after reset");

endmodule
